// ===== sv/mrrc_pkg.sv =====
`timescale 1ns / 1ps
// shared types, constants and crc-16 byte update for the modbus rtu response checker
// no dependencies

package mrrc_pkg;

    localparam logic [15:0] CRC_PRESET = 16'hFFFF;
    localparam logic [15:0] CRC_POLY   = 16'hA001;

    localparam logic [7:0] FUNC_READ_HOLDING = 8'h03;
    localparam logic [7:0] FUNC_READ_INPUT   = 8'h04;
    localparam logic [7:0] FUNC_WRITE_SINGLE = 8'h06;
    localparam logic [7:0] REG_PARAM_RELOAD  = 8'h05;

    localparam int NUM_HOLDING = 6;
    localparam int NUM_INPUT   = 2;

    localparam logic [2:0] ST_CRC_BAD       = 3'd0;
    localparam logic [2:0] ST_ADDR_MISMATCH = 3'd1;
    localparam logic [2:0] ST_FUNC_IGNORED  = 3'd2;
    localparam logic [2:0] ST_READ_HOLDING  = 3'd3;
    localparam logic [2:0] ST_READ_INPUT    = 3'd4;
    localparam logic [2:0] ST_WRITE_ECHO    = 3'd5;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       last_byte;
    } beat_t;

    typedef struct packed {
        logic [2:0]                       status;
        logic [NUM_HOLDING-1:0][7:0]      holding;
        logic [NUM_INPUT-1:0][7:0]        input_regs;
        logic                             request_params;
    } result_t;

    function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                               input logic [7:0]  data);
        logic [15:0] c;
        c = crc_in ^ {8'h00, data};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

// ===== sv/mrrc_frame.sv =====
`timescale 1ns / 1ps
// per-frame state: crc over delayed bytes, field capture and end-of-frame decode
// depends on mrrc_pkg

module mrrc_frame import mrrc_pkg::*; #(
    parameter int CAPTURED_REGISTERS = 6
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       step,
    input  beat_t      beat,
    input  logic [7:0] slave_address,
    output result_t    result
);

    logic [15:0] crc_reg, crc_next;
    logic [7:0]  pos_reg, pos_next;
    logic [1:0][7:0] held_reg, held_next;
    logic [7:0]  addr_reg, addr_next;
    logic [7:0]  func_reg, func_next;
    logic [7:0]  third_reg, third_next;
    logic [CAPTURED_REGISTERS-1:0][7:0] regs_reg, regs_next;

    logic [15:0] crc_base, crc_upd;
    logic [7:0]  kidx;
    logic        capture;
    logic [NUM_HOLDING-1:0][7:0] hold_w;

    always_comb begin
        crc_base = (pos_reg == 8'd0) ? CRC_PRESET : crc_reg;
        crc_upd  = (pos_reg >= 8'd2) ? crc16_byte(crc_base, held_reg[0]) : crc_base;
        held_next[0] = held_reg[1];
        held_next[1] = beat.frame_byte;
        addr_next  = (pos_reg == 8'd0) ? beat.frame_byte : addr_reg;
        func_next  = (pos_reg == 8'd1) ? beat.frame_byte : func_reg;
        third_next = (pos_reg == 8'd3) ? beat.frame_byte : third_reg;
        kidx    = 8'(pos_reg - 8'd4) >> 1;
        capture = (pos_reg >= 8'd4) && !pos_reg[0];
        for (int i = 0; i < CAPTURED_REGISTERS; i++) begin
            if (pos_reg == 8'd0) begin
                regs_next[i] = 8'h00;
            end else if (capture && kidx == 8'(i)) begin
                regs_next[i] = beat.frame_byte;
            end else begin
                regs_next[i] = regs_reg[i];
            end
        end
        if (beat.last_byte) begin
            pos_next = 8'd0;
            crc_next = CRC_PRESET;
        end else begin
            pos_next = (pos_reg == 8'd255) ? pos_reg : pos_reg + 8'd1;
            crc_next = crc_upd;
        end
    end

    for (genvar j = 0; j < NUM_HOLDING; j++) begin : g_hold
        if (j < CAPTURED_REGISTERS) begin : g_have
            assign hold_w[j] = regs_next[j];
        end else begin : g_none
            assign hold_w[j] = 8'h00;
        end
    end

    always_comb begin
        result = '0;
        priority if (pos_reg < 8'd3 || crc_upd != {held_next[0], held_next[1]}) begin
            result.status = ST_CRC_BAD;
        end else if (addr_next != slave_address) begin
            result.status = ST_ADDR_MISMATCH;
        end else if (func_next == FUNC_READ_HOLDING) begin
            result.status = ST_READ_HOLDING;
        end else if (func_next == FUNC_READ_INPUT) begin
            result.status = ST_READ_INPUT;
        end else if (func_next == FUNC_WRITE_SINGLE) begin
            result.status = ST_WRITE_ECHO;
        end else begin
            result.status = ST_FUNC_IGNORED;
        end
        unique case (result.status)
            ST_READ_HOLDING: begin
                result.holding = hold_w;
            end
            ST_READ_INPUT: begin
                result.input_regs[0] = regs_next[0];
                result.input_regs[1] = regs_next[1];
            end
            ST_WRITE_ECHO: begin
                result.request_params = (third_next == REG_PARAM_RELOAD);
            end
            default: begin
                result.request_params = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            crc_reg <= CRC_PRESET;
            pos_reg <= 8'd0;
        end else if (step) begin
            crc_reg <= crc_next;
            pos_reg <= pos_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            held_reg  <= held_next;
            addr_reg  <= addr_next;
            func_reg  <= func_next;
            third_reg <= third_next;
            regs_reg  <= regs_next;
        end
    end

endmodule

// ===== sv/modbus_rtu_response_checker.sv =====
`timescale 1ns / 1ps
// Modbus RTU response checker top level: input register, frame logic, result register
// depends on mrrc_pkg and mrrc_frame
//
// Takes one response byte per beat with a last-byte mark and accepts a beat every cycle
// unless a last byte waits. A CRC-16 (preset 0xFFFF, poly 0xA001) runs over all but the
// trailing two bytes, which are compared high byte first. On the last byte one result beat
// gives the status and the low bytes of the captured registers. Only a last byte waits, and
// only while the previous result still sits unread in the output register; all other bytes
// pass at one per cycle. Frames under four bytes report a bad crc. The user must write the
// expected slave address through cfg_wr_en / cfg_wr_data while idle; the block does not enforce it.

module modbus_rtu_response_checker import mrrc_pkg::*; #(
    parameter int CAPTURED_REGISTERS = 6
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_wr_en,
    input  logic [7:0] cfg_wr_data,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_frame_byte,
    input  logic       s_last_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [2:0] m_status,
    output logic [7:0] m_channel_count,
    output logic [7:0] m_sync_setting,
    output logic [7:0] m_fan_setting,
    output logic [7:0] m_power_setting,
    output logic [7:0] m_alarm_temperature,
    output logic [7:0] m_mode_setting,
    output logic [7:0] m_alarm_code,
    output logic [7:0] m_signal_level,
    output logic       m_request_params
);

    logic [7:0] slave_address_reg;
    logic       in_valid_reg;
    beat_t      in_reg;
    logic       m_valid_reg;
    result_t    result_reg;
    result_t    result_w;
    logic       out_free;
    logic       advance;

    assign out_free = !m_valid_reg || m_ready;
    assign advance  = in_valid_reg && (!in_reg.last_byte || out_free);
    assign s_ready  = !in_valid_reg || advance;

    mrrc_frame #(
        .CAPTURED_REGISTERS(CAPTURED_REGISTERS)
    ) u_frame (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .step          (advance),
        .beat          (in_reg),
        .slave_address (slave_address_reg),
        .result        (result_w)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slave_address_reg <= 8'd220;
            in_valid_reg      <= 1'b0;
            m_valid_reg       <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                slave_address_reg <= cfg_wr_data;
            end
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance && in_reg.last_byte) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg.frame_byte <= s_frame_byte;
            in_reg.last_byte  <= s_last_byte;
        end
        if (advance && in_reg.last_byte) begin
            result_reg <= result_w;
        end
    end

    assign m_valid             = m_valid_reg;
    assign m_status            = result_reg.status;
    assign m_channel_count     = result_reg.holding[0];
    assign m_sync_setting      = result_reg.holding[1];
    assign m_fan_setting       = result_reg.holding[2];
    assign m_power_setting     = result_reg.holding[3];
    assign m_alarm_temperature = result_reg.holding[4];
    assign m_mode_setting      = result_reg.holding[5];
    assign m_alarm_code        = result_reg.input_regs[0];
    assign m_signal_level      = result_reg.input_regs[1];
    assign m_request_params    = result_reg.request_params;

endmodule
